// ===== rtl/core/matrix4x4_multiply_defines.svh =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply assertion macros
// shared concurrent assertion forms, clocked on clk_i with reset rst_ni
// ----------------------------------------------------------------------------
`ifndef MATRIX4X4_MULTIPLY_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_DEFINES_SVH

// checked only outside reset
`define MM4X4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked during reset as well
`define MM4X4_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/mm4x4_pkg.sv =====
// ----------------------------------------------------------------------------
// mm4x4_pkg
// types and constants of the 4x4 fixed-point matrix multiplier
// ----------------------------------------------------------------------------
`default_nettype none

package mm4x4_pkg;

  localparam int unsigned ELEMENT_WIDTH = 32;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DIM           = 4;
  localparam int unsigned IDX_W         = 2;
  localparam int unsigned KIND_W        = 2;

  localparam int unsigned PROD_W  = 2 * ELEMENT_WIDTH;
  localparam int unsigned PAIR_W  = PROD_W + 1;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned SHIFT_W = SUM_W - FRAC_BITS;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic signed [DATA_W-1:0]        data_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_LEFT  = 2'd0,
    KIND_LOAD_RIGHT = 2'd1,
    KIND_COMPUTE    = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic [IDX_W-1:0]          column;
    logic [DIM-1:0][ELEMENT_WIDTH-1:0] elem;
  } cmd_t;

  localparam elem_t ELEM_MAX = elem_t'({1'b0, {(ELEMENT_WIDTH-1){1'b1}}});
  localparam elem_t ELEM_MIN = elem_t'({1'b1, {(ELEMENT_WIDTH-1){1'b0}}});
  localparam data_t DATA_MAX = DATA_W'(ELEM_MAX);
  localparam data_t DATA_MIN = DATA_W'(ELEM_MIN);

endpackage

`default_nettype wire

// ===== rtl/core/mm4x4_if.sv =====
// ----------------------------------------------------------------------------
// mm4x4 channel interfaces
// valid/ready channels for input items and result columns
// ----------------------------------------------------------------------------
`default_nettype none

interface mm4x4_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  column;
  logic [31:0] elem0;
  logic [31:0] elem1;
  logic [31:0] elem2;
  logic [31:0] elem3;

  modport source (output valid, kind, column, elem0, elem1, elem2, elem3, input ready);
  modport sink   (input valid, kind, column, elem0, elem1, elem2, elem3, output ready);
endinterface

interface mm4x4_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_column;
  logic [31:0] out_elem0;
  logic [31:0] out_elem1;
  logic [31:0] out_elem2;
  logic [31:0] out_elem3;
  logic        saturated;
  logic        last;

  modport source (output valid, out_column, out_elem0, out_elem1, out_elem2, out_elem3,
                  saturated, last, input ready);
  modport sink   (input valid, out_column, out_elem0, out_elem1, out_elem2, out_elem3,
                  saturated, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mm4x4_front.sv =====
// ----------------------------------------------------------------------------
// mm4x4_front
// accepts input items, drops unused kinds, registers commands for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module mm4x4_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  mm4x4_in_if.sink             in_i,
  output mm4x4_pkg::cmd_t      cmd_o,
  output logic                 cmd_valid_o,
  input  wire logic            cmd_ready_i
);

  logic            hold_valid_q, hold_valid_d;
  mm4x4_pkg::cmd_t hold_q, cmd_d;
  logic            accept, keep, known_kind, push_fire;

  assign push_fire  = hold_valid_q && cmd_ready_i;
  assign in_i.ready = !hold_valid_q || cmd_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    unique case (in_i.kind) inside
      mm4x4_pkg::KIND_LOAD_LEFT, mm4x4_pkg::KIND_LOAD_RIGHT,
      mm4x4_pkg::KIND_COMPUTE: known_kind = 1'b1;
      default:                 known_kind = 1'b0;
    endcase
  end

  assign keep = accept && known_kind;

  always_comb begin
    cmd_d.kind    = mm4x4_pkg::kind_e'(in_i.kind);
    cmd_d.column  = in_i.column;
    cmd_d.elem[0] = in_i.elem0[mm4x4_pkg::ELEMENT_WIDTH-1:0];
    cmd_d.elem[1] = in_i.elem1[mm4x4_pkg::ELEMENT_WIDTH-1:0];
    cmd_d.elem[2] = in_i.elem2[mm4x4_pkg::ELEMENT_WIDTH-1:0];
    cmd_d.elem[3] = in_i.elem3[mm4x4_pkg::ELEMENT_WIDTH-1:0];
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (keep) begin
      hold_valid_d = 1'b1;
    end else if (push_fire) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      hold_q <= cmd_d;
    end
  end

  assign cmd_o       = hold_q;
  assign cmd_valid_o = hold_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/mm4x4_queue.sv =====
// ----------------------------------------------------------------------------
// mm4x4_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module mm4x4_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mm4x4_pkg::cmd_t   push_i,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  output mm4x4_pkg::cmd_t        pop_o,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i
);

  mm4x4_pkg::cmd_t                  entry_q [mm4x4_pkg::QDEPTH];
  logic [mm4x4_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mm4x4_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                             do_push, do_pop;

  assign push_ready_o = (count_q != mm4x4_pkg::QCNT_W'(mm4x4_pkg::QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_o        = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == mm4x4_pkg::QPTR_W'(mm4x4_pkg::QDEPTH - 1)) ? '0
                                                                        : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == mm4x4_pkg::QPTR_W'(mm4x4_pkg::QDEPTH - 1)) ? '0
                                                                        : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mm4x4_back.sv =====
// ----------------------------------------------------------------------------
// mm4x4_back
// matrix storage and the multiply pipeline: products, pair sums, final sum
// with shift and saturation into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module mm4x4_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mm4x4_pkg::cmd_t   cmd_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  mm4x4_out_if.source            out_o
);

  localparam int unsigned DIM = mm4x4_pkg::DIM;
  localparam int unsigned EW  = mm4x4_pkg::ELEMENT_WIDTH;
  localparam int unsigned FB  = mm4x4_pkg::FRAC_BITS;

  // storage indexed [column][row]
  logic signed [EW-1:0] left_q  [DIM][DIM];
  logic signed [EW-1:0] right_q [DIM][DIM];

  logic [mm4x4_pkg::IDX_W-1:0] col_cnt_q, col_cnt_d;
  logic is_load, is_compute, last_issue, issue, adv;

  logic                                 s1_valid_q, s2_valid_q, out_valid_q;
  logic [mm4x4_pkg::IDX_W-1:0]          s1_col_q, s2_col_q, out_col_q;
  logic signed [mm4x4_pkg::PROD_W-1:0]  s1_prod_q [DIM][DIM];
  logic signed [mm4x4_pkg::PAIR_W-1:0]  s2_pair_q [DIM][2];
  logic signed [EW-1:0]                 out_elem_q [DIM];
  logic                                 out_sat_q;

  logic signed [mm4x4_pkg::SUM_W-1:0]   sum_w   [DIM];
  logic signed [mm4x4_pkg::SHIFT_W-1:0] shift_w [DIM];
  logic signed [EW-1:0]                 clip_w  [DIM];
  logic                                 sat_w;

  assign adv        = !out_valid_q || out_o.ready;
  assign is_load    = cmd_valid_i && ((cmd_i.kind == mm4x4_pkg::KIND_LOAD_LEFT) ||
                                      (cmd_i.kind == mm4x4_pkg::KIND_LOAD_RIGHT));
  assign is_compute = cmd_valid_i && (cmd_i.kind == mm4x4_pkg::KIND_COMPUTE);
  assign issue      = is_compute && adv;
  assign last_issue = (col_cnt_q == mm4x4_pkg::IDX_W'(DIM - 1));

  always_comb begin
    if (is_compute) begin
      cmd_ready_o = adv && last_issue;
    end else begin
      cmd_ready_o = 1'b1;
    end
  end

  always_comb begin
    col_cnt_d = col_cnt_q;
    if (issue) begin
      col_cnt_d = last_issue ? '0 : col_cnt_q + 1'b1;
    end
  end

  // matrix stores
  always_ff @(posedge clk_i) begin
    if (is_load) begin
      for (int r = 0; r < DIM; r++) begin
        if (cmd_i.kind == mm4x4_pkg::KIND_LOAD_LEFT) begin
          left_q[cmd_i.column][r] <= cmd_i.elem[r];
        end else begin
          right_q[cmd_i.column][r] <= cmd_i.elem[r];
        end
      end
    end
  end

  // final sum, shift and clip
  always_comb begin
    sat_w = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      sum_w[r]   = mm4x4_pkg::SUM_W'(s2_pair_q[r][0]) + mm4x4_pkg::SUM_W'(s2_pair_q[r][1]);
      shift_w[r] = sum_w[r][mm4x4_pkg::SUM_W-1:FB];
      if (shift_w[r] > mm4x4_pkg::SHIFT_W'(mm4x4_pkg::ELEM_MAX)) begin
        clip_w[r] = mm4x4_pkg::ELEM_MAX;
        sat_w     = 1'b1;
      end else if (shift_w[r] < mm4x4_pkg::SHIFT_W'(mm4x4_pkg::ELEM_MIN)) begin
        clip_w[r] = mm4x4_pkg::ELEM_MIN;
        sat_w     = 1'b1;
      end else begin
        clip_w[r] = shift_w[r][EW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_cnt_q <= col_cnt_d;
      if (adv) begin
        s1_valid_q  <= issue;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_col_q  <= col_cnt_q;
      s2_col_q  <= s1_col_q;
      out_col_q <= s2_col_q;
      out_sat_q <= sat_w;
      for (int r = 0; r < DIM; r++) begin
        for (int k = 0; k < DIM; k++) begin
          s1_prod_q[r][k] <= left_q[k][r] * right_q[col_cnt_q][k];
        end
        s2_pair_q[r][0] <= mm4x4_pkg::PAIR_W'(s1_prod_q[r][0])
                         + mm4x4_pkg::PAIR_W'(s1_prod_q[r][1]);
        s2_pair_q[r][1] <= mm4x4_pkg::PAIR_W'(s1_prod_q[r][2])
                         + mm4x4_pkg::PAIR_W'(s1_prod_q[r][3]);
        out_elem_q[r]   <= clip_w[r];
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_column = out_col_q;
  assign out_o.out_elem0  = mm4x4_pkg::DATA_W'(out_elem_q[0]);
  assign out_o.out_elem1  = mm4x4_pkg::DATA_W'(out_elem_q[1]);
  assign out_o.out_elem2  = mm4x4_pkg::DATA_W'(out_elem_q[2]);
  assign out_o.out_elem3  = mm4x4_pkg::DATA_W'(out_elem_q[3]);
  assign out_o.saturated  = out_sat_q;
  assign out_o.last       = (out_col_q == mm4x4_pkg::IDX_W'(DIM - 1));

endmodule

`default_nettype wire

// ===== rtl/core/matrix4x4_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// product of two column-major 4x4 signed Q16.16 matrices
// ----------------------------------------------------------------------------
// A load item writes one column of the left or right matrix and is retired
// by the back end without waiting on the output. A compute item produces
// four result columns, column 0 first, one per cycle when the output is not
// stalled, through a bank of sixteen multipliers, and each column passes the
// product, pair-sum and output registers in that order. A one-item input
// register and a two-entry command queue decouple the input from the result
// side. Each element is the exact sum of four products, shifted right by the
// fraction width (floor) and clipped to 32 bits; saturated marks a clipped
// column and last marks column 3. Matrix entries read before they are loaded
// return arbitrary values. Kind 3 items are accepted and discarded.
`default_nettype none

`include "matrix4x4_multiply_defines.svh"

module matrix4x4_multiply (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  mm4x4_in_if.sink      in_i,
  mm4x4_out_if.source   out_o
);

  mm4x4_pkg::cmd_t front_cmd, queue_cmd;
  logic            front_valid, front_ready, queue_valid, queue_ready;

  mm4x4_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  mm4x4_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_o        (queue_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  mm4x4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .out_o       (out_o)
  );

  `MM4X4_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> !out_o.valid,
                       "result valid during reset")

  `MM4X4_ASSERT(a_last_on_col3,
                out_o.valid |-> (out_o.last == (out_o.out_column == 2'd3)),
                "last flag does not match column 3")

  `MM4X4_ASSERT(a_sat_at_bound,
                (out_o.valid && out_o.saturated) |->
                  ((out_o.out_elem0 == mm4x4_pkg::DATA_MAX) ||
                   (out_o.out_elem0 == mm4x4_pkg::DATA_MIN) ||
                   (out_o.out_elem1 == mm4x4_pkg::DATA_MAX) ||
                   (out_o.out_elem1 == mm4x4_pkg::DATA_MIN) ||
                   (out_o.out_elem2 == mm4x4_pkg::DATA_MAX) ||
                   (out_o.out_elem2 == mm4x4_pkg::DATA_MIN) ||
                   (out_o.out_elem3 == mm4x4_pkg::DATA_MAX) ||
                   (out_o.out_elem3 == mm4x4_pkg::DATA_MIN)),
                "saturated column with no element at a bound")

  `MM4X4_ASSERT(a_col_order,
                (out_o.valid && out_o.ready && !out_o.last) |=>
                  (!out_o.valid || (out_o.out_column == $past(out_o.out_column) + 2'd1)),
                "result columns out of order")

endmodule

`default_nettype wire

// ===== dv/mm4x4_product_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mm4x4_product_checker
// watches the input and result channels of the 4x4 matrix multiplier, keeps
// its own copy of both matrices, predicts every result column of a compute
// item and compares the columns that leave the block in order
// ----------------------------------------------------------------------------

module mm4x4_product_checker
  import mm4x4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mm4x4_in_if         in_mon_i,
  mm4x4_out_if        out_mon_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [IDX_W-1:0]             column;
    logic [DIM-1:0][DATA_W-1:0]   elem;
    logic                         saturated;
    logic                         last;
  } result_col_t;

  localparam logic signed [SUM_W-1:0] SUM_HI = ELEM_MAX;
  localparam logic signed [SUM_W-1:0] SUM_LO = ELEM_MIN;

  elem_t                      left_m  [DIM*DIM];
  elem_t                      right_m [DIM*DIM];
  result_col_t                expected_columns [$];
  result_col_t                exp_col;
  result_col_t                got_col;
  logic [DIM-1:0][DATA_W-1:0] load_col;
  int unsigned                error_count = 0;
  int unsigned                pending_count = 0;

  assign error_count_o = error_count;
  assign pending_o     = pending_count;

  function automatic result_col_t column_product(int unsigned j);
    result_col_t                res;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SUM_W-1:0]    acc;
    logic signed [SUM_W-1:0]    shifted;
    res.column    = IDX_W'(j);
    res.saturated = 1'b0;
    res.last      = (j == DIM - 1);
    for (int i = 0; i < DIM; i++) begin
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        prod = left_m[k*DIM + i] * right_m[j*DIM + k];
        acc  = acc + prod;
      end
      shifted = acc >>> FRAC_BITS;
      if (shifted > SUM_HI) begin
        shifted       = SUM_HI;
        res.saturated = 1'b1;
      end else if (shifted < SUM_LO) begin
        shifted       = SUM_LO;
        res.saturated = 1'b1;
      end
      res.elem[i] = DATA_W'(elem_t'(shifted));
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        load_col = {in_mon_i.elem3, in_mon_i.elem2, in_mon_i.elem1, in_mon_i.elem0};
        case (in_mon_i.kind)
          KIND_LOAD_LEFT: begin
            for (int r = 0; r < DIM; r++)
              left_m[in_mon_i.column*DIM + r] = elem_t'(load_col[r]);
          end
          KIND_LOAD_RIGHT: begin
            for (int r = 0; r < DIM; r++)
              right_m[in_mon_i.column*DIM + r] = elem_t'(load_col[r]);
          end
          KIND_COMPUTE: begin
            for (int unsigned j = 0; j < DIM; j++)
              expected_columns.push_back(column_product(j));
          end
          default: begin
          end
        endcase
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got_col.column    = out_mon_i.out_column;
        got_col.elem      = {out_mon_i.out_elem3, out_mon_i.out_elem2,
                             out_mon_i.out_elem1, out_mon_i.out_elem0};
        got_col.saturated = out_mon_i.saturated;
        got_col.last      = out_mon_i.last;
        if (expected_columns.size() == 0) begin
          $display("%0t: unexpected result column, actual column %0d", $time,
                   got_col.column);
          error_count++;
        end else begin
          exp_col = expected_columns.pop_front();
          if (got_col.column !== exp_col.column) begin
            $display("%0t: out_column expected %0d actual %0d", $time,
                     exp_col.column, got_col.column);
            error_count++;
          end
          for (int r = 0; r < DIM; r++) begin
            if (got_col.elem[r] !== exp_col.elem[r]) begin
              $display("%0t: column %0d out_elem%0d expected %h actual %h", $time,
                       exp_col.column, r, exp_col.elem[r], got_col.elem[r]);
              error_count++;
            end
          end
          if (got_col.saturated !== exp_col.saturated) begin
            $display("%0t: column %0d saturated expected %b actual %b", $time,
                     exp_col.column, exp_col.saturated, got_col.saturated);
            error_count++;
          end
          if (got_col.last !== exp_col.last) begin
            $display("%0t: column %0d last expected %b actual %b", $time,
                     exp_col.column, exp_col.last, got_col.last);
            error_count++;
          end
        end
      end
      pending_count = expected_columns.size();
    end
  end

endmodule

// ===== dv/tb_matrix4x4_multiply.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix4x4_multiply
// drives load, compute and unused-kind items into the 4x4 matrix multiplier with
// directed extremes, a back-pressure burst and random phases of sender
// idling and receiver stalls; the checker beside the block predicts and
// compares every result column
// ----------------------------------------------------------------------------

module tb_matrix4x4_multiply;
  import mm4x4_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
  localparam int unsigned       CLK_PERIOD   = 12;
  localparam int unsigned       RESET_CYCLES = 11;
  localparam int unsigned       LIMIT_CYCLES = 200000;
  localparam int unsigned       DRAIN_CYCLES = 24;
  localparam int unsigned       HOLD_CYCLES  = 300;
  localparam int unsigned       BURST_ITEMS  = 16;
  localparam int unsigned       PHASE_ITEMS  = 96;
  localparam data_t             Q_ONE        = 32'h0001_0000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned error_count;
  int unsigned pending_count;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned rx_hold_cycles = 0;

  int unsigned tx_idle_plan  [4] = '{0, 70, 0, 27};
  int unsigned rx_stall_plan [4] = '{0, 0, 70, 27};

  mm4x4_in_if  in_if ();
  mm4x4_out_if out_if ();

  matrix4x4_multiply i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mm4x4_product_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon_i      (in_if),
    .out_mon_i     (out_if),
    .error_count_o (error_count),
    .pending_o     (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  function automatic data_t random_elem();
    data_t v;
    case ($urandom_range(0, 9))
      5:       v = $urandom;
      6:       v = ELEM_MAX;
      7:       v = ELEM_MIN;
      8:       v = $urandom_range(0, 16) - 8;
      9:       v = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      default: v = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endcase
    return v;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] col,
                           input data_t e0, input data_t e1,
                           input data_t e2, input data_t e3);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.kind   <= kind;
    in_if.column <= col;
    in_if.elem0  <= e0;
    in_if.elem1  <= e1;
    in_if.elem2  <= e2;
    in_if.elem3  <= e3;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_random();
    int unsigned         pick;
    logic [KIND_W-1:0]   kind;
    pick = $urandom_range(0, 99);
    if (pick < 38)      kind = KIND_LOAD_LEFT;
    else if (pick < 76) kind = KIND_LOAD_RIGHT;
    else if (pick < 95) kind = KIND_COMPUTE;
    else                kind = KIND_UNUSED;
    send_item(kind, IDX_W'($urandom_range(0, 3)), random_elem(), random_elem(),
              random_elem(), random_elem());
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        out_if.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.kind   <= '0;
    in_if.column <= '0;
    in_if.elem0  <= '0;
    in_if.elem1  <= '0;
    in_if.elem2  <= '0;
    in_if.elem3  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // identity on the left, mixed extremes on the right
    for (int c = 0; c < DIM; c++)
      send_item(KIND_LOAD_LEFT, IDX_W'(c), (c == 0) ? Q_ONE : '0, (c == 1) ? Q_ONE : '0,
                (c == 2) ? Q_ONE : '0, (c == 3) ? Q_ONE : '0);
    send_item(KIND_LOAD_RIGHT, 2'd0, ELEM_MAX, ELEM_MIN, -1, 0);
    send_item(KIND_LOAD_RIGHT, 2'd1, 1, -1, Q_ONE, -Q_ONE);
    send_item(KIND_UNUSED, 2'd3, ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MIN);
    send_item(KIND_LOAD_RIGHT, 2'd2, 32'h0000_8000, 32'hFFFF_8000, 3, -3);
    send_item(KIND_LOAD_RIGHT, 2'd3, random_elem(), random_elem(), random_elem(),
              random_elem());
    send_item(KIND_COMPUTE, 2'd3, '0, '0, '0, '0);

    // clipping in both directions
    for (int c = 0; c < DIM; c++)
      send_item(KIND_LOAD_LEFT, IDX_W'(c), ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_item(KIND_COMPUTE, 2'd0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_item(KIND_LOAD_RIGHT, 2'd0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_item(KIND_LOAD_RIGHT, 2'd1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_item(KIND_COMPUTE, 2'd1, '0, '0, '0, '0);
    send_item(KIND_LOAD_LEFT, 2'd0, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_item(KIND_LOAD_LEFT, 2'd1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_item(KIND_COMPUTE, 2'd2, '0, '0, '0, '0);
    send_item(KIND_UNUSED, 2'd0, '0, '0, '0, '0);

    // long output hold-off while computes keep coming
    rx_hold_cycles = HOLD_CYCLES;
    repeat (BURST_ITEMS)
      send_item(KIND_COMPUTE, IDX_W'($urandom_range(0, 3)), $urandom, $urandom,
                $urandom, $urandom);

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_idle_plan[p];
      rx_stall_pct = rx_stall_plan[p];
      repeat (PHASE_ITEMS) send_random();
    end
    in_if.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mm4x4_pkg.sv
rtl/core/mm4x4_if.sv
rtl/core/mm4x4_front.sv
rtl/core/mm4x4_queue.sv
rtl/core/mm4x4_back.sv
rtl/core/matrix4x4_multiply.sv
dv/mm4x4_product_checker.sv
dv/tb_matrix4x4_multiply.sv
